@@ src/tcw_pkg.sv @@
package tcw_pkg;

   // Default geometry of the screen
   localparam int DEF_COLUMNS  = 80;
   localparam int DEF_ROWS     = 25;
   localparam int DEF_TAB_STOP = 8;

   // Port field widths
   localparam int MODE_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = CHAR_W + ATTR_W;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd31;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // Decoded operation of an incoming transaction
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
   localparam logic [OP_W-1:0] OP_PUT     = 3'd1;
   localparam logic [OP_W-1:0] OP_NEWLINE = 3'd2;
   localparam logic [OP_W-1:0] OP_TAB     = 3'd3;
   localparam logic [OP_W-1:0] OP_BS      = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;
   localparam logic [OP_W-1:0] OP_READ    = 3'd6;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // capture the incoming transaction
      logic put;        // write a cell at the cursor and advance
      logic put_space;  // the put writes a space instead of the request character
      logic newline;    // cursor to column 0 of the next row
      logic backspace;  // step back and blank that cell
      logic home;       // cursor to the top left corner
      logic tab_load;   // load the tab space count
      logic tab_dec;    // one tab space written
      logic read;       // issue a read of the requested cell
      logic scroll;     // one step of the scroll sweep
      logic fill;       // one step of the clear sweep
      logic finish;     // load the result register
   } tcw_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            at_last_col;
      logic            at_bottom;
      logic            col_zero;
      logic            tab_last;
      logic            tab_zero;
      logic            sweep_last;
      logic            rsp_free;
   } tcw_status_type;

endpackage

@@ src/tcw_ctrl.sv @@
module tcw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type    cmd
);
   import tcw_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TAB    = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_CLEAR  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Sequence the work of one transaction
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (status.op)
                  OP_PUT: begin
                     cmd.put = 1'b1;
                     if (status.at_last_col && status.at_bottom) begin
                        state_in = ST_SCROLL;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  OP_NEWLINE: begin
                     cmd.newline = 1'b1;
                     state_in = status.at_bottom ? ST_SCROLL : ST_FINISH;
                  end
                  OP_BS: begin
                     cmd.backspace = !status.col_zero;
                     state_in = ST_FINISH;
                  end
                  OP_TAB: begin
                     cmd.tab_load = 1'b1;
                     state_in = ST_TAB;
                  end
                  OP_CLEAR: begin
                     cmd.home = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  OP_READ: begin
                     cmd.read = 1'b1;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_TAB: begin
            cmd.put       = 1'b1;
            cmd.put_space = 1'b1;
            cmd.tab_dec   = 1'b1;
            if (status.at_last_col && status.at_bottom) begin
               state_in = ST_SCROLL;
            end else if (status.tab_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_SCROLL: begin
            cmd.scroll = 1'b1;
            if (status.sweep_last) begin
               state_in = status.tab_zero ? ST_FINISH : ST_TAB;
            end
         end
         ST_CLEAR: begin
            cmd.fill = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/tcw_datapath.sv @@
module tcw_datapath #(
   parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS     = tcw_pkg::DEF_ROWS,
   parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tcw_pkg::tcw_cmd_type                 cmd,
   output tcw_pkg::tcw_status_type              status,
   input  logic [tcw_pkg::MODE_W-1:0]           req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]           req_char_code,
   input  logic [tcw_pkg::ROW_OUT_W-1:0]        req_read_row,
   input  logic [tcw_pkg::COL_OUT_W-1:0]        req_read_col,
   input  logic                                 csr_valid,
   input  logic [tcw_pkg::ATTR_W-1:0]           csr_text_attribute,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tcw_pkg::ROW_OUT_W-1:0]        rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0]        rsp_cursor_col,
   output logic [tcw_pkg::CHAR_W-1:0]           rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]           rsp_cell_attr,
   output logic                                 rsp_scrolled
);
   import tcw_pkg::*;

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int MOD_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
   localparam int TCNT_W = $clog2(TAB_STOP + 1);

   localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [MOD_W-1:0]  MOD_LAST   = MOD_W'(TAB_STOP - 1);
   localparam logic [TCNT_W-1:0] TAB_FULL   = TCNT_W'(TAB_STOP);
   localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

   // Screen store: attribute in the high byte, character in the low byte
   logic [CELL_W-1:0] mem [CELLS];

   logic [ROW_W-1:0]    cur_row_ff, cur_row_in;
   logic [COL_W-1:0]    cur_col_ff, cur_col_in;
   logic [MOD_W-1:0]    tab_mod_ff, tab_mod_in;
   logic [TCNT_W-1:0]   tab_left_ff, tab_left_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic [CHAR_W-1:0]   fill_char_ff, fill_char_in;
   logic                is_read_ff, is_read_in;
   logic                scrolled_ff, scrolled_in;
   logic                wr_pend_ff, wr_pend_in;
   logic                wr_copy_ff, wr_copy_in;
   logic [ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0]   wr_data_ff, wr_data_in;
   logic [CELL_W-1:0]   rdata_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]   rsp_attr_ff, rsp_attr_in;
   logic                rsp_scrolled_ff, rsp_scrolled_in;

   logic [OP_W-1:0]     op_dec;
   logic [ADDR_W-1:0]   cur_addr;
   logic [ADDR_W-1:0]   rq_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_en;
   logic                copy_phase;
   logic [31:0]         rq_row_w, rq_col_w;
   logic [31:0]         row_wide, col_wide;
   logic [CELL_W-1:0]   mem_wdata;
   logic [CHAR_W-1:0]   put_char;

   // Decode the incoming transaction
   always_comb begin
      op_dec = OP_NONE;
      case (req_mode)
         MODE_PUT: begin
            if (req_char_code inside {CH_CR, CH_LF}) begin
               op_dec = OP_NEWLINE;
            end else if (req_char_code == CH_TAB) begin
               op_dec = OP_TAB;
            end else if (req_char_code == CH_BS) begin
               op_dec = OP_BS;
            end else begin
               op_dec = OP_PUT;
            end
         end
         MODE_CLEAR: op_dec = OP_CLEAR;
         MODE_READ:  op_dec = OP_READ;
         default:    op_dec = OP_NONE;
      endcase
   end

   assign status.op          = op_dec;
   assign status.at_last_col = (cur_col_ff == COL_LAST);
   assign status.at_bottom   = (cur_row_ff == ROW_LAST);
   assign status.col_zero    = (cur_col_ff == '0);
   assign status.tab_last    = (tab_left_ff == TCNT_W'(1));
   assign status.tab_zero    = (tab_left_ff == '0);
   assign status.sweep_last  = (sweep_ff == SWEEP_LAST);
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   // Linear addresses of the cursor and of the requested cell
   assign cur_addr = ADDR_W'(32'(cur_row_ff) * 32'(COLUMNS) + 32'(cur_col_ff));

   always_comb begin
      rq_row_w = 32'(req_read_row);
      rq_col_w = 32'(req_read_col);
      if (rq_row_w > 32'(ROWS - 1)) begin
         rq_row_w = 32'(ROWS - 1);
      end
      if (rq_col_w > 32'(COLUMNS - 1)) begin
         rq_col_w = 32'(COLUMNS - 1);
      end
   end

   assign rq_addr = ADDR_W'(rq_row_w * 32'(COLUMNS) + rq_col_w);

   // Cursor movement
   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      tab_mod_in = tab_mod_ff;
      if (cmd.home) begin
         cur_row_in = '0;
         cur_col_in = '0;
         tab_mod_in = '0;
      end else if (cmd.put) begin
         if (status.at_last_col) begin
            cur_col_in = '0;
            tab_mod_in = '0;
            if (!status.at_bottom) begin
               cur_row_in = cur_row_ff + ROW_W'(1);
            end
         end else begin
            cur_col_in = cur_col_ff + COL_W'(1);
            tab_mod_in = (tab_mod_ff == MOD_LAST) ? '0 : tab_mod_ff + MOD_W'(1);
         end
      end else if (cmd.newline) begin
         cur_col_in = '0;
         tab_mod_in = '0;
         if (!status.at_bottom) begin
            cur_row_in = cur_row_ff + ROW_W'(1);
         end
      end else if (cmd.backspace) begin
         cur_col_in = cur_col_ff - COL_W'(1);
         tab_mod_in = (tab_mod_ff == '0) ? MOD_LAST : tab_mod_ff - MOD_W'(1);
      end
   end

   // Tab space count, sweep counter and transaction flags
   always_comb begin
      tab_left_in  = tab_left_ff;
      fill_char_in = fill_char_ff;
      is_read_in   = is_read_ff;
      scrolled_in  = scrolled_ff;
      attr_in      = csr_valid ? csr_text_attribute : attr_ff;
      if (cmd.accept) begin
         tab_left_in  = '0;
         fill_char_in = req_char_code;
         is_read_in   = (status.op == OP_READ);
         scrolled_in  = 1'b0;
      end
      if (cmd.tab_load) begin
         tab_left_in = TAB_FULL - TCNT_W'(tab_mod_ff);
      end else if (cmd.tab_dec) begin
         tab_left_in = tab_left_ff - TCNT_W'(1);
      end
      if (cmd.scroll) begin
         scrolled_in = 1'b1;
      end
      sweep_in = (cmd.scroll || cmd.fill) ? sweep_ff + ADDR_W'(1) : '0;
   end

   // Queue one store write a cycle; the copy data arrives from the read port
   assign copy_phase = cmd.scroll && (sweep_ff < COPY_END);
   assign put_char   = cmd.put_space ? CH_SPACE : req_char_code;

   always_comb begin
      wr_pend_in = cmd.put || cmd.backspace || cmd.scroll || cmd.fill;
      wr_copy_in = copy_phase;
      wr_addr_in = sweep_ff;
      wr_data_in = {attr_ff, CH_SPACE};
      if (cmd.put) begin
         wr_addr_in = cur_addr;
         wr_data_in = {attr_ff, put_char};
      end else if (cmd.backspace) begin
         wr_addr_in = cur_addr - ADDR_W'(1);
      end else if (cmd.fill) begin
         wr_data_in = {attr_ff, fill_char_ff};
      end
   end

   assign mem_wdata = wr_copy_ff ? rdata_ff : wr_data_ff;
   assign rd_en     = cmd.read || copy_phase;
   assign rd_addr   = cmd.read ? rq_addr : sweep_ff + ROW_STRIDE;

   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         mem[wr_addr_ff] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Result register
   assign row_wide = 32'(cur_row_ff);
   assign col_wide = 32'(cur_col_ff);

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_row_in      = rsp_row_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_attr_in     = rsp_attr_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      if (cmd.finish) begin
         rsp_valid_in    = 1'b1;
         rsp_row_in      = row_wide[ROW_OUT_W-1:0];
         rsp_col_in      = col_wide[COL_OUT_W-1:0];
         rsp_char_in     = is_read_ff ? rdata_ff[CHAR_W-1:0] : '0;
         rsp_attr_in     = is_read_ff ? rdata_ff[CELL_W-1:CHAR_W] : '0;
         rsp_scrolled_in = scrolled_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         tab_mod_ff   <= '0;
         tab_left_ff  <= '0;
         sweep_ff     <= '0;
         attr_ff      <= ATTR_RESET;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         tab_mod_ff   <= tab_mod_in;
         tab_left_ff  <= tab_left_in;
         sweep_ff     <= sweep_in;
         attr_ff      <= attr_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      fill_char_ff    <= fill_char_in;
      is_read_ff      <= is_read_in;
      scrolled_ff     <= scrolled_in;
      wr_copy_ff      <= wr_copy_in;
      wr_addr_ff      <= wr_addr_in;
      wr_data_ff      <= wr_data_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_attr_ff     <= rsp_attr_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

endmodule

@@ src/text_console_writer.sv @@
// Text console writer: a ROWS x COLUMNS screen store of 16-bit cells
// (attribute high byte, character low byte) with a write cursor.
// Request channel (req_): mode 0 puts a character (CR, LF, tab and
// backspace are interpreted), mode 1 fills the screen and homes the
// cursor, mode 2 reads one cell with its position clamped to the screen.
// Every request gives one response (rsp_) carrying the cursor, the read
// cell (zero outside mode 2) and a scroll flag.
// csr_ writes the attribute byte; it is always ready and should be
// written only while no request is in flight.
// A tab writes one space per step; a clear, and every scroll (each row
// copied up, then the bottom row blanked), sweeps the whole store
// through the single write port one cell a cycle.
// One request is in flight at a time: a new one is taken only once the
// previous one has finished. The response sits in an output register:
// a new request is taken while it waits, and a stalled receiver blocks
// only the finish.
// Reset homes the cursor, sets the attribute to 31 and drops any response;
// the screen store is undefined until written or cleared.
module text_console_writer #(
   parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS     = tcw_pkg::DEF_ROWS,
   parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_text_attribute,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcw_pkg::MODE_W-1:0]    req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::ROW_OUT_W-1:0] req_read_row,
   input  logic [tcw_pkg::COL_OUT_W-1:0] req_read_col,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tcw_pkg::ROW_OUT_W-1:0] rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0] rsp_cursor_col,
   output logic [tcw_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]    rsp_cell_attr,
   output logic                          rsp_scrolled
);
   import tcw_pkg::*;

   tcw_cmd_type    cmd;
   tcw_status_type status;

   // Attribute writes are taken at any time
   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_mode),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .csr_valid          (csr_valid),
      .csr_text_attribute (csr_text_attribute),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr),
      .rsp_scrolled       (rsp_scrolled)
   );

endmodule

@@ tb/text_console_checker.sv @@
module text_console_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_text_attribute,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [tcw_pkg::MODE_W-1:0]    req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::ROW_OUT_W-1:0] req_read_row,
   input  logic [tcw_pkg::COL_OUT_W-1:0] req_read_col,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [tcw_pkg::ROW_OUT_W-1:0] rsp_cursor_row,
   input  logic [tcw_pkg::COL_OUT_W-1:0] rsp_cursor_col,
   input  logic [tcw_pkg::CHAR_W-1:0]    rsp_cell_char,
   input  logic [tcw_pkg::ATTR_W-1:0]    rsp_cell_attr,
   input  logic                          rsp_scrolled,
   output int                            mismatch_count,
   output int                            pending_count,
   output int                            scroll_count,
   output int                            read_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam int COLUMNS  = DEF_COLUMNS;
   localparam int ROWS     = DEF_ROWS;
   localparam int TAB_STOP = DEF_TAB_STOP;
   localparam int CELLS    = ROWS * COLUMNS;

   typedef struct packed {
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
      logic [CHAR_W-1:0]    glyph;
      logic [ATTR_W-1:0]    attr;
      logic                 scrolled;
   } console_rsp_type;

   // Shadow copy of the screen, cursor and attribute
   logic [CELL_W-1:0] screen [CELLS];
   int                cur_row = 0;
   int                cur_col = 0;
   logic [ATTR_W-1:0] attr_now = ATTR_RESET;
   logic              scrolled_now;

   console_rsp_type expected_q [$];
   int              errors = 0;
   int              scroll_total = 0;
   int              read_total = 0;

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Return to column 0 of the next row, scrolling up on the bottom row
   function automatic void line_feed();
      int i;
      cur_col = 0;
      if (cur_row >= ROWS - 1) begin
         for (i = 0; i < CELLS - COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
         for (i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = {attr_now, CH_SPACE};
         scrolled_now = 1'b1;
      end else begin
         cur_row++;
      end
   endfunction

   // Write a cell at the cursor and advance, wrapping at the last column
   function automatic void write_glyph(input logic [CHAR_W-1:0] ch);
      screen[cur_row * COLUMNS + cur_col] = {attr_now, ch};
      cur_col++;
      if (cur_col >= COLUMNS)
         line_feed();
   endfunction

   // Apply one request to the shadow screen and build its response
   function automatic console_rsp_type predict_console(input logic [MODE_W-1:0]    mode,
                                                       input logic [CHAR_W-1:0]    ch,
                                                       input logic [ROW_OUT_W-1:0] rr,
                                                       input logic [COL_OUT_W-1:0] rc);
      console_rsp_type r;
      int              row_sel;
      int              col_sel;
      int              spaces;
      int              i;
      r = '0;
      scrolled_now = 1'b0;
      case (mode)
         MODE_PUT: begin
            case (ch)
               CH_CR, CH_LF: line_feed();
               CH_TAB: begin
                  spaces = TAB_STOP - (cur_col % TAB_STOP);
                  repeat (spaces) write_glyph(CH_SPACE);
               end
               CH_BS: begin
                  // backspace at column 0 does nothing
                  if (cur_col > 0) begin
                     cur_col--;
                     screen[cur_row * COLUMNS + cur_col] = {attr_now, CH_SPACE};
                  end
               end
               default: write_glyph(ch);
            endcase
         end
         MODE_CLEAR: begin
            for (i = 0; i < CELLS; i++)
               screen[i] = {attr_now, ch};
            cur_row = 0;
            cur_col = 0;
         end
         MODE_READ: begin
            // clamp the position to the screen
            row_sel = (int'(rr) > ROWS - 1) ? ROWS - 1 : int'(rr);
            col_sel = (int'(rc) > COLUMNS - 1) ? COLUMNS - 1 : int'(rc);
            {r.attr, r.glyph} = screen[row_sel * COLUMNS + col_sel];
            read_total++;
         end
         default: ;
      endcase
      if (scrolled_now)
         scroll_total++;
      r.row      = ROW_OUT_W'(cur_row);
      r.col      = COL_OUT_W'(cur_col);
      r.scrolled = scrolled_now;
      return r;
   endfunction

   // Watch the three channels: compare responses, track the attribute, predict requests
   always @(posedge clock) begin
      console_rsp_type want;
      if (reset) begin
         expected_q.delete();
         cur_row  = 0;
         cur_col  = 0;
         attr_now = ATTR_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("response with nothing outstanding", 1, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_cursor_row !== want.row)
                  report_mismatch("cursor_row", int'(rsp_cursor_row), int'(want.row));
               if (rsp_cursor_col !== want.col)
                  report_mismatch("cursor_col", int'(rsp_cursor_col), int'(want.col));
               if (rsp_cell_char !== want.glyph)
                  report_mismatch("cell_char", int'(rsp_cell_char), int'(want.glyph));
               if (rsp_cell_attr !== want.attr)
                  report_mismatch("cell_attr", int'(rsp_cell_attr), int'(want.attr));
               if (rsp_scrolled !== want.scrolled)
                  report_mismatch("scrolled", int'(rsp_scrolled), int'(want.scrolled));
            end
         end
         if (csr_valid && csr_ready)
            attr_now = csr_text_attribute;
         if (req_valid && req_ready)
            expected_q.push_back(predict_console(req_mode, req_char_code,
                                                 req_read_row, req_read_col));
      end
      // publish counts after the edge so the stimulus never races them
      pending_count  <= expected_q.size();
      mismatch_count <= errors;
      scroll_count   <= scroll_total;
      read_count     <= read_total;
   end

endmodule

@@ tb/text_console_writer_tb.sv @@
module text_console_writer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 190;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [ATTR_W-1:0]    csr_text_attribute = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [MODE_W-1:0]    req_mode = MODE_PUT;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic [ROW_OUT_W-1:0] req_read_row = '0;
   logic [COL_OUT_W-1:0] req_read_col = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ROW_OUT_W-1:0] rsp_cursor_row;
   logic [COL_OUT_W-1:0] rsp_cursor_col;
   logic [CHAR_W-1:0]    rsp_cell_char;
   logic [ATTR_W-1:0]    rsp_cell_attr;
   logic                 rsp_scrolled;

   int mismatch_count;
   int pending_count;
   int scroll_count;
   int read_count;

   int idle_pct = 32;
   int sent_count = 0;
   int clear_count = 0;
   int attr_writes = 0;

   text_console_writer u_top (.*);

   text_console_checker u_checker (.*);

   always #5 clock = ~clock;

   // Receiver: stall at random according to the current idle rate
   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct);

   // Hard stop in case the block hangs
   initial begin
      #100_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Random field values over the full port width
   function automatic logic [CHAR_W-1:0] any_char();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [ROW_OUT_W-1:0] any_row();
      return ROW_OUT_W'($urandom_range(0, 31));
   endfunction

   function automatic logic [COL_OUT_W-1:0] any_col();
      return COL_OUT_W'($urandom_range(0, 127));
   endfunction

   // Present one request after a random gap and hold it until accepted
   task automatic send_request(input logic [MODE_W-1:0]    mode,
                               input logic [CHAR_W-1:0]    ch,
                               input logic [ROW_OUT_W-1:0] row,
                               input logic [COL_OUT_W-1:0] col);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_char_code <= ch;
      req_read_row  <= row;
      req_read_col  <= col;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (mode == MODE_CLEAR)
         clear_count++;
   endtask

   // Drop valid and hold until every outstanding response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Write the attribute register; only called while the block is idle
   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      csr_valid          <= 1'b1;
      csr_text_attribute <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      attr_writes++;
   endtask

   // One random request, or a burst of CR/LF requests that pushes the cursor toward the bottom row
   task automatic send_random();
      int pick;
      int burst;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         send_request(MODE_CLEAR, any_char(), any_row(), any_col());
      end else if (pick < 4) begin
         burst = $urandom_range(18, 30);
         repeat (burst)
            send_request(MODE_PUT, $urandom_range(0, 1) ? CH_LF : CH_CR,
                         any_row(), any_col());
      end else if (pick < 9) begin
         send_request(MODE_PUT, $urandom_range(0, 1) ? CH_LF : CH_CR,
                      any_row(), any_col());
      end else if (pick < 13) begin
         send_request(MODE_PUT, CH_TAB, any_row(), any_col());
      end else if (pick < 17) begin
         send_request(MODE_PUT, CH_BS, any_row(), any_col());
      end else if (pick < 32) begin
         // mostly in range, sometimes past the edge to exercise clamping
         send_request(MODE_READ, any_char(),
                      ($urandom_range(0, 99) < 80) ? ROW_OUT_W'($urandom_range(0, 24))
                                                   : any_row(),
                      ($urandom_range(0, 99) < 80) ? COL_OUT_W'($urandom_range(0, 79))
                                                   : any_col());
      end else if (pick < 34) begin
         send_request(MODE_UNUSED, any_char(), any_row(), any_col());
      end else begin
         send_request(MODE_PUT, any_char(), any_row(), any_col());
      end
   endtask

   initial begin
      logic [ATTR_W-1:0] phase_attr [PHASES];
      int                phase;
      int                start_count;

      phase_attr[0] = 8'h00;
      phase_attr[1] = ATTR_W'($urandom_range(0, 255));
      phase_attr[2] = ATTR_RESET;
      phase_attr[3] = ATTR_W'($urandom_range(0, 255));
      phase_attr[4] = 8'hFF;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: clear first so no read ever touches an unwritten cell
      write_attribute(8'hFF);
      send_request(MODE_CLEAR, 8'h41, 0, 0);
      send_request(MODE_READ, 0, 0, 0);
      send_request(MODE_PUT, 8'h78, 0, 0);
      send_request(MODE_PUT, 8'h00, 0, 0);
      send_request(MODE_PUT, 8'hFF, 0, 0);
      send_request(MODE_PUT, CH_BS, 0, 0);
      send_request(MODE_READ, 0, 0, 2);
      send_request(MODE_PUT, CH_CR, 0, 0);
      send_request(MODE_PUT, CH_BS, 0, 0);
      send_request(MODE_PUT, CH_TAB, 0, 0);
      send_request(MODE_PUT, 8'h61, 0, 0);
      send_request(MODE_PUT, CH_TAB, 0, 0);
      send_request(MODE_PUT, CH_LF, 0, 0);
      send_request(MODE_READ, 0, 1, 8);
      send_request(MODE_READ, 0, 31, 127);
      send_request(MODE_READ, 0, 24, 0);
      send_request(MODE_READ, 0, 0, 127);
      send_request(MODE_READ, 0, 31, 79);
      send_request(MODE_UNUSED, 8'hFF, 31, 127);
      wait_for_drain();

      // Random phases, each under its own attribute; the middle one never idles
      for (phase = 0; phase < PHASES; phase++) begin
         write_attribute(phase_attr[phase]);
         idle_pct = (phase == 2) ? 0 : 32;
         start_count = sent_count;
         while (sent_count - start_count < PHASE_ITEMS) begin
            send_random();
            if ($urandom_range(0, 99) == 0)
               wait_for_drain();
         end
         wait_for_drain();
      end
      idle_pct = 32;

      repeat (20) @(posedge clock);
      $display("covered %0d transactions: %0d clears, %0d reads, %0d scrolling, %0d attributes",
               sent_count, clear_count, read_count, scroll_count, attr_writes);
      if (mismatch_count == 0 && pending_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
